// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the deque block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define BDQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define BDQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/bdq_pkg.sv =====
// ---------------------------------------------------------------------------
// Bounded deque package
// Command codes, cell operations and the structs that link the cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdq_pkg;

   // Command codes carried in the request tuser field.
   localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
   localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
   localparam logic [1:0] CMD_REMOVE     = 2'd2;

   localparam int VALUE_W = 32;

   // Operation broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_SHIFT_IN,
      OP_APPEND,
      OP_CLOSE
   } op_type;

   typedef struct packed {
      op_type                      op;
      logic signed [VALUE_W-1:0]   key;
   } cell_ctl_type;

   // Contents of one cell as seen by its neighbours.
   typedef struct packed {
      logic                        valid;
      logic signed [VALUE_W-1:0]   value;
   } cell_link_type;

endpackage

// ===== hw/rtl/bdq_cell.sv =====
// ---------------------------------------------------------------------------
// Deque cell
// Holds one entry and takes its next contents from itself, its left or right
// neighbour, or the broadcast key, as the current operation asks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdq_cell
   import bdq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctl_type  ctl,
   input  cell_link_type left_link,
   input  cell_link_type right_link,
   input  logic          found_left,
   output cell_link_type cell_state,
   output logic          found_right
);

   logic                      valid_ff;
   logic                      valid_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      match;

   // A match here, or anywhere to the left, marks the first occurrence.
   assign match       = valid_ff && (value_ff == ctl.key);
   assign found_right = found_left | match;

   // Next contents of the cell.
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      unique case (ctl.op)
         OP_HOLD: begin
            valid_in = valid_ff;
         end
         OP_SHIFT_IN: begin
            valid_in = left_link.valid;
            value_in = left_link.value;
         end
         OP_APPEND: begin
            if (!valid_ff && left_link.valid) begin
               valid_in = 1'b1;
               value_in = ctl.key;
            end
         end
         OP_CLOSE: begin
            if (found_right) begin
               valid_in = right_link.valid;
               value_in = right_link.value;
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   // Valid bit is control state; the value needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign cell_state.valid = valid_ff;
   assign cell_state.value = value_ff;

endmodule

// ===== hw/rtl/bounded_deque_with_value_delete.sv =====
// ---------------------------------------------------------------------------
// Bounded deque with delete by value
// Ordered list of up to CAPACITY signed words with front and back insertion
// and removal of the first matching word.
// ---------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, the front in cell 0. Every
// command completes across the whole row in the clock cycle in which its word
// is accepted: a front insert shifts all cells one place back, a back insert
// fills the first empty cell, and a removal compares every cell against the
// key and closes the gap behind the first match, found by a flag passed from
// cell to cell. An accepted command is held as pending until its result word
// loads into the output register. The block takes one command word per clock
// for as long as results are taken; a stalled result holds back at most one
// further command, after which the request side waits. Reset empties the list
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounded_deque_with_value_delete
   import bdq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Command side.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // Result side.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [0] ok, [1] empty_res, [6:2] count,
                                    // [38:7] front_value, [70:39] back_value,
                                    // [71] zero
);

   localparam int CW = $clog2(CAPACITY + 1);

   cell_ctl_type              ctl;
   cell_link_type             cells   [CAPACITY];
   logic          [CAPACITY:0] found_chain;
   logic          [CAPACITY-1:0] valid_vec;
   logic          [CAPACITY-1:0] tail_vec;

   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic                      pend_ff;
   logic                      pend_in;
   logic                      pend_ok_ff;
   logic                      pend_ok_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [71:0]               rsp_data_ff;
   logic [71:0]               rsp_data_in;

   logic                      accept;
   logic                      load;
   logic                      full;
   logic                      found_any;
   op_type                    op_sel;
   logic                      op_ok;
   logic signed [VALUE_W-1:0] back_value;
   logic signed [VALUE_W-1:0] front_value;
   logic [CW+4:0]             count_ext;

   // Handshake: a new word may enter while the pending result moves out.
   assign load       = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_ff || load;
   assign accept     = req_tvalid && req_tready;

   assign full      = (count_ff == CW'(CAPACITY));
   assign found_any = found_chain[CAPACITY];

   // Decode the command into the operation broadcast to the cells.
   always_comb begin
      op_sel = OP_HOLD;
      op_ok  = 1'b0;
      unique case (req_tuser)
         CMD_PUSH_FRONT: begin
            if (!full) begin
               op_sel = OP_SHIFT_IN;
               op_ok  = 1'b1;
            end
         end
         CMD_PUSH_BACK: begin
            if (!full) begin
               op_sel = OP_APPEND;
               op_ok  = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (found_any) begin
               op_sel = OP_CLOSE;
               op_ok  = 1'b1;
            end
         end
         default: begin
            op_sel = OP_HOLD;
         end
      endcase
   end

   assign ctl.op  = accept ? op_sel : OP_HOLD;
   assign ctl.key = req_tdata;

   // Row of cells; cell 0 sees the key as a valid left neighbour.
   assign found_chain[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_type left_link;
      cell_link_type right_link;

      if (i == 0) begin : g_head
         assign left_link.valid = 1'b1;
         assign left_link.value = req_tdata;
      end else begin : g_body
         assign left_link = cells[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_link.valid = 1'b0;
         assign right_link.value = '0;
      end else begin : g_inner
         assign right_link = cells[i+1];
      end

      bdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_link   (left_link),
         .right_link  (right_link),
         .found_left  (found_chain[i]),
         .cell_state  (cells[i]),
         .found_right (found_chain[i+1])
      );

      assign valid_vec[i] = cells[i].valid;
   end

   // The back entry is the last valid cell.
   assign tail_vec = valid_vec & ~(valid_vec >> 1);

   always_comb begin
      back_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         back_value = back_value | ({VALUE_W{tail_vec[i]}} & cells[i].value);
      end
   end

   assign front_value = cells[0].valid ? cells[0].value : '0;
   assign count_ext   = {5'b0, count_ff};

   // Entry count follows the operation applied to the cells.
   always_comb begin
      count_in = count_ff;
      unique case (ctl.op)
         OP_HOLD:     count_in = count_ff;
         OP_SHIFT_IN: count_in = count_ff + CW'(1);
         OP_APPEND:   count_in = count_ff + CW'(1);
         OP_CLOSE:    count_in = count_ff - CW'(1);
         default:     count_in = count_ff;
      endcase
   end

   // Pending result and output register.
   always_comb begin
      pend_in      = accept || (pend_ff && !load);
      pend_ok_in   = accept ? op_ok : pend_ok_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_data_in = {1'b0, back_value, front_value, count_ext[4:0],
                        !cells[0].valid, pend_ok_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_ok_ff  <= pend_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks on the cell row and the result path.
   `BDQ_ASSERT_ALWAYS(a_count_bound, reset || count_ff <= CW'(CAPACITY), "count above capacity")
   `BDQ_ASSERT(a_valid_matches_count, $countones(valid_vec) == int'(count_ff) && (valid_vec & (valid_vec + 1'b1)) == '0, "valid cells are not a packed prefix matching the count")
   `BDQ_ASSERT(a_accept_pends, accept |=> pend_ff, "accepted command left no pending result")
   `BDQ_ASSERT(a_front_grows, accept && req_tuser == CMD_PUSH_FRONT && !full |=> count_ff == $past(count_ff) + CW'(1) && cells[0].value == $past(ctl.key), "front insert did not land in cell 0")

endmodule
